>>> hw/rtl/vn3c_pkg.sv
`default_nettype none
package vn3c_pkg;

  typedef enum logic [1:0] {
    CMD_WR_VALUE = 2'd0,
    CMD_WR_PERM  = 2'd1,
    CMD_EVAL     = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  // Width of spline knots and intermediate Horner values
  localparam int unsigned KW = 24;
  localparam int unsigned CW = 28;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HZ,
    ST_HY,
    ST_HX,
    ST_VAL,
    ST_VWAIT,
    ST_SPL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic          start;
    logic [KW-1:0] k0;
    logic [KW-1:0] k1;
    logic [KW-1:0] k2;
    logic [KW-1:0] k3;
  } spl_req_t;

endpackage
`default_nettype wire

>>> hw/rtl/value_noise_3d_cubic.sv
`default_nettype none
// Evaluate: 64 lookups (z, y and x perm hashes, value read, value wait) plus 21 splines.
// out_valid rises once the final z spline is done and stays high until out_ready.
// Loads leave the block idle. One item at a time; in_ready is low while an evaluate runs.
// Lookups are bound by the single read port of each table and the perm hash chain.
// Result is held in an output register until out_ready.
// Synchronous active-low reset clears control; tables are undefined until written.
module value_noise_3d_cubic #(
  parameter int unsigned TABLE_SIZE = 256,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_cmd,
  input  wire logic [7:0]         in_table_index,
  input  wire logic signed [15:0] in_lattice_value,
  input  wire logic [7:0]         in_perm_entry,
  input  wire logic signed [31:0] in_x_coord,
  input  wire logic signed [31:0] in_y_coord,
  input  wire logic signed [31:0] in_z_coord,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [16:0]      out_noise_value
);
  import vn3c_pkg::*;

  localparam int unsigned AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int unsigned IW = 32 - FRAC_BITS;

  state_t st_r, st_nxt;

  // Tables
  logic signed [15:0] vtab [TABLE_SIZE];
  logic [7:0]         ptab [TABLE_SIZE];
  logic [AW-1:0]      p_addr, v_addr;
  logic [7:0]         p_rd_r;
  logic signed [15:0] v_rd_r;

  // Item registers
  logic [IW-1:0]        bx_r, by_r, bz_r;
  logic [FRAC_BITS-1:0] fx_r, fy_r, fz_r;
  logic [1:0]  i_r, j_r, k_r;
  logic [1:0]  lvl_r;       // 0: x spline, 1: y spline, 2: z spline
  logic signed [KW-1:0] xk_r [4];
  logic signed [KW-1:0] yk_r [4];
  logic signed [KW-1:0] zk_r [4];
  logic signed [16:0] res_r;

  spl_req_t             sreq;
  logic [FRAC_BITS-1:0] st_t;
  logic                 s_done;
  logic signed [KW-1:0] s_res;

  logic in_acc;
  assign in_acc = in_valid && in_ready;
  assign in_ready  = (st_r == ST_IDLE);
  assign out_valid = (st_r == ST_OUT);
  assign out_noise_value = res_r;

  // Table address selection
  always_comb begin
    unique case (st_r)
      ST_HZ:   p_addr = AW'(bz_r + IW'(k_r) - IW'(1));
      ST_HY:   p_addr = AW'(by_r + IW'(j_r) - IW'(1) + IW'(p_rd_r));
      default: p_addr = AW'(bx_r + IW'(i_r) - IW'(1) + IW'(p_rd_r));
    endcase
  end
  assign v_addr = AW'(p_rd_r);

  always_ff @(posedge clk) begin
    if (in_acc && in_cmd == CMD_WR_VALUE && 32'(in_table_index) < TABLE_SIZE)
      vtab[AW'(in_table_index)] <= in_lattice_value;
    if (in_acc && in_cmd == CMD_WR_PERM && 32'(in_table_index) < TABLE_SIZE)
      ptab[AW'(in_table_index)] <= in_perm_entry;
    p_rd_r <= ptab[p_addr];
    v_rd_r <= vtab[v_addr];
  end

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:  if (in_acc && in_cmd == CMD_EVAL) st_nxt = ST_HZ;
      ST_HZ:    st_nxt = ST_HY;
      ST_HY:    st_nxt = ST_HX;
      ST_HX:    st_nxt = ST_VAL;
      ST_VAL:   st_nxt = ST_VWAIT;
      ST_VWAIT: st_nxt = (i_r == 2'd3) ? ST_SPL : ST_HZ;
      ST_SPL: begin
        if (s_done) begin
          priority if (lvl_r == 2'd2) st_nxt = ST_OUT;
          else if (lvl_r == 2'd1 && k_r != 2'd3) st_nxt = ST_HZ;
          else if (lvl_r == 2'd0 && j_r != 2'd3) st_nxt = ST_HZ;
          else st_nxt = ST_SPL;
        end
      end
      ST_OUT:   if (out_ready) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // Spline request; the last knot of a new spline is the value arriving this cycle
  always_comb begin
    sreq.start = 1'b0;
    sreq.k0 = xk_r[0]; sreq.k1 = xk_r[1]; sreq.k2 = xk_r[2]; sreq.k3 = xk_r[3];
    st_t = fx_r;
    unique case (lvl_r)
      2'd1: begin
        sreq.k0 = yk_r[0]; sreq.k1 = yk_r[1]; sreq.k2 = yk_r[2]; sreq.k3 = yk_r[3];
        st_t = fy_r;
      end
      2'd2: begin
        sreq.k0 = zk_r[0]; sreq.k1 = zk_r[1]; sreq.k2 = zk_r[2]; sreq.k3 = zk_r[3];
        st_t = fz_r;
      end
      default: ;
    endcase
    if (st_r == ST_VWAIT && i_r == 2'd3) begin
      sreq.start = 1'b1;
      sreq.k0 = xk_r[0]; sreq.k1 = xk_r[1]; sreq.k2 = xk_r[2]; sreq.k3 = KW'(v_rd_r);
    end
    if (st_r == ST_SPL && s_done && st_nxt == ST_SPL) begin
      sreq.start = 1'b1;
      if (lvl_r == 2'd0) begin
        sreq.k0 = yk_r[0]; sreq.k1 = yk_r[1]; sreq.k2 = yk_r[2]; sreq.k3 = s_res;
      end else begin
        sreq.k0 = zk_r[0]; sreq.k1 = zk_r[1]; sreq.k2 = zk_r[2]; sreq.k3 = s_res;
      end
    end
  end

  vn3c_spline #(.FRAC_BITS(FRAC_BITS)) u_spline (
    .clk(clk), .rst_n(rst_n), .req(sreq), .t(st_t), .done(s_done), .result(s_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      i_r   <= 2'd0;
      j_r   <= 2'd0;
      k_r   <= 2'd0;
      lvl_r <= 2'd0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_IDLE) begin
        i_r <= 2'd0; j_r <= 2'd0; k_r <= 2'd0; lvl_r <= 2'd0;
      end
      if (st_r == ST_VWAIT) begin
        i_r <= i_r + 2'd1;
        if (i_r == 2'd3) lvl_r <= 2'd0;
      end
      if (st_r == ST_SPL && s_done) begin
        unique case (lvl_r)
          2'd0: begin
            j_r <= j_r + 2'd1;
            if (j_r == 2'd3) lvl_r <= 2'd1;
          end
          2'd1: begin
            k_r <= k_r + 2'd1;
            lvl_r <= (k_r == 2'd3) ? 2'd2 : 2'd0;
          end
          default: lvl_r <= 2'd2;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      bx_r <= in_x_coord[31:FRAC_BITS];
      by_r <= in_y_coord[31:FRAC_BITS];
      bz_r <= in_z_coord[31:FRAC_BITS];
      fx_r <= in_x_coord[FRAC_BITS-1:0];
      fy_r <= in_y_coord[FRAC_BITS-1:0];
      fz_r <= in_z_coord[FRAC_BITS-1:0];
    end
    if (st_r == ST_VWAIT) xk_r[i_r] <= KW'(v_rd_r);
    if (st_r == ST_SPL && s_done) begin
      unique case (lvl_r)
        2'd0:    yk_r[j_r] <= s_res;
        2'd1:    zk_r[k_r] <= s_res;
        default: begin
          if (s_res > KW'(65535))       res_r <= 17'sd65535;
          else if (s_res < -KW'(65536)) res_r <= -17'sd65536;
          else                          res_r <= 17'(s_res);
        end
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_noise_value))
    else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != ST_IDLE |-> !in_ready) else $error("ready while busy");
  a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_cmd == CMD_EVAL |=> st_r == ST_HZ) else $error("eval not started");
endmodule
`default_nettype wire

>>> hw/rtl/vn3c_spline.sv
`default_nettype none
// Catmull-Rom spline, one Horner step per cycle on a shared multiplier
module vn3c_spline #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire vn3c_pkg::spl_req_t     req,
  input  wire logic [FRAC_BITS-1:0]   t,
  output logic                        done,
  output logic signed [vn3c_pkg::KW-1:0] result
);
  import vn3c_pkg::*;

  logic signed [CW-1:0] c2_r, c1_r, c0_r, acc_r, acc_nxt;
  logic [1:0] step_r, step_nxt;
  logic busy_r, busy_nxt;
  logic signed [CW-1:0] k0, k1, k2, k3;
  logic signed [CW+FRAC_BITS:0] prod;
  logic signed [CW-1:0] addend;
  logic signed [CW-1:0] fin;

  assign k0 = CW'($signed(req.k0));
  assign k1 = CW'($signed(req.k1));
  assign k2 = CW'($signed(req.k2));
  assign k3 = CW'($signed(req.k3));

  // Shared multiply and add
  assign prod = acc_r * $signed({1'b0, t});
  always_comb begin
    unique case (step_r)
      2'd0:    addend = c2_r;
      2'd1:    addend = c1_r;
      default: addend = c0_r;
    endcase
  end
  assign acc_nxt = CW'(prod >>> FRAC_BITS) + addend;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = 2'd0;
    end else if (busy_r) begin
      step_nxt = step_r + 2'd1;
      if (step_r == 2'd2) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
      done   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      done   <= busy_r && step_r == 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= CW'(-k0 + 3 * k1 - 3 * k2 + k3);
      c2_r  <= CW'(2 * k0 - 5 * k1 + 4 * k2 - k3);
      c1_r  <= k2 - k0;
      c0_r  <= CW'(2 * k1);
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign fin    = (acc_r + CW'(1)) >>> 1;
  assign result = KW'(fin);

  property p_done_after_busy;
    @(posedge clk) disable iff (!rst_n) done |-> $past(busy_r);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("spline done w/o busy");
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> step_r != 2'd3) else $error("spline step overrun");
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("spline done held");
endmodule
`default_nettype wire
